FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the reader block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bara_pkg.sv
// Package with types and constants of the bridge converter reader.
`default_nettype none

package bara_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_W     = 7;
    localparam int GAIN_W      = 24;
    localparam int WEIGHT_W    = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int TIMER_W     = 5;
    localparam int SUM_W       = SAMPLE_BITS + COUNT_W;
    localparam int BIT_W       = $clog2(SAMPLE_BITS + 1);
    localparam int SUB_W       = ((SAMPLE_BITS > WEIGHT_W) ? SAMPLE_BITS : WEIGHT_W) + 2;

    localparam logic [TIMER_W-1:0]     RESET_TICKS  = TIMER_W'(20);
    localparam logic [TIMER_W-1:0]     SETTLE_TICKS = TIMER_W'(2);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MSB   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [COUNT_W-1:0]     COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0]     COUNT_RESET  = COUNT_W'(10);
    localparam logic [GAIN_W-1:0]      GAIN_RESET   = GAIN_W'(65536);

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_MEASURE = 2'd1,
        OP_TARE    = 2'd2,
        OP_RESET   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AVG_COUNT = 2'd0,
        CFG_GAIN      = 2'd1,
        CFG_OFFSET    = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_WAIT      = 4'd1,
        PH_SETTLE    = 4'd2,
        PH_BIT_HIGH  = 4'd3,
        PH_BIT_LOW   = 4'd4,
        PH_GAIN_HIGH = 4'd5,
        PH_GAIN_LOW  = 4'd6,
        PH_RESET     = 4'd7
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_DIV  = 2'd1,
        CS_MUL  = 2'd2
    } calc_state_t;

    typedef struct packed {
        logic sck;
        logic busy;
        logic done;
    } step_res_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic               is_tare;
    } calc_op_t;

endpackage

`default_nettype wire

FILE: rtl/core/bara_ifs.sv
// Request and result channel interfaces of the bridge converter reader.
`default_nettype none

interface bara_in_if
    import bara_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       dout_level;

    modport source (output valid, output op, output dout_level, input ready);
    modport sink (input valid, input op, input dout_level, output ready);
endinterface

interface bara_out_if
    import bara_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       sck_level;
    logic                       busy_res;
    logic                       weight_valid;
    logic signed [WEIGHT_W-1:0] weight;

    modport source (output valid, output sck_level, output busy_res, output weight_valid,
                    output weight, input ready);
    modport sink (input valid, input sck_level, input busy_res, input weight_valid,
                  input weight, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bara_ctrl.sv
// Tick sequencer that clocks the converter bits in serially and sums the samples.
`default_nettype none

module bara_ctrl
    import bara_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [1:0]         op,
    input  wire logic               dout_level,
    input  wire logic [COUNT_W-1:0] average_count,
    output step_res_t               res,
    output calc_op_t                calc
);

    phase_t                 phase_reg, phase_next;
    logic [TIMER_W-1:0]     timer_reg, timer_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [SAMPLE_BITS-1:0] shift_reg, shift_next;
    logic [COUNT_W-1:0]     samples_reg, samples_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   discard_reg, discard_next;
    logic                   tare_reg, tare_next;
    logic                   clock_reg, clock_next;
    logic                   done;
    logic [COUNT_W-1:0]     need;
    logic [BIT_W-1:0]       bit_inc;
    op_t                    op_code;

    assign op_code = op_t'(op);
    assign need    = (average_count == '0) ? COUNT_W'(1) : average_count;
    assign bit_inc = bit_reg + BIT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            samples_reg <= '0;
            sum_reg     <= '0;
            discard_reg <= 1'b0;
            tare_reg    <= 1'b0;
            clock_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            samples_reg <= samples_next;
            sum_reg     <= sum_next;
            discard_reg <= discard_next;
            tare_reg    <= tare_next;
            clock_reg   <= clock_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        samples_next = samples_reg;
        sum_next     = sum_reg;
        discard_next = discard_reg;
        tare_next    = tare_reg;
        clock_next   = clock_reg;
        done         = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                clock_next = 1'b0;
                if (op_code inside {OP_MEASURE, OP_TARE})
                begin
                    tare_next    = (op_code == OP_TARE);
                    discard_next = 1'b1;
                    samples_next = '0;
                    sum_next     = '0;
                    bit_next     = '0;
                    shift_next   = '0;
                    timer_next   = '0;
                    phase_next   = PH_WAIT;
                end
                else if (op_code == OP_RESET)
                begin
                    clock_next = 1'b1;
                    timer_next = TIMER_W'(1);
                    phase_next = PH_RESET;
                end
            end
            PH_RESET:
            begin
                if (timer_reg >= RESET_TICKS)
                begin
                    clock_next = 1'b0;
                    timer_next = '0;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    timer_next = timer_reg + TIMER_W'(1);
                end
            end
            PH_WAIT:
            begin
                clock_next = 1'b0;
                if (!dout_level)
                begin
                    timer_next = '0;
                    phase_next = PH_SETTLE;
                end
            end
            PH_SETTLE:
            begin
                if (timer_reg >= SETTLE_TICKS)
                begin
                    clock_next = 1'b1;
                    timer_next = '0;
                    phase_next = PH_BIT_HIGH;
                end
                else
                begin
                    timer_next = timer_reg + TIMER_W'(1);
                end
            end
            PH_BIT_HIGH:
            begin
                clock_next = 1'b0;
                phase_next = PH_BIT_LOW;
            end
            PH_BIT_LOW:
            begin
                shift_next = {shift_reg[SAMPLE_BITS-2:0], dout_level};
                bit_next   = bit_inc;
                clock_next = 1'b1;
                timer_next = '0;
                phase_next = (bit_inc >= BIT_W'(SAMPLE_BITS)) ? PH_GAIN_HIGH : PH_BIT_HIGH;
            end
            PH_GAIN_HIGH:
            begin
                if (timer_reg >= TIMER_W'(1))
                begin
                    clock_next = 1'b0;
                    timer_next = '0;
                    phase_next = PH_GAIN_LOW;
                end
                else
                begin
                    timer_next = timer_reg + TIMER_W'(1);
                end
            end
            PH_GAIN_LOW:
            begin
                if (timer_reg < TIMER_W'(1))
                begin
                    timer_next = timer_reg + TIMER_W'(1);
                end
                else
                begin
                    if (discard_reg)
                    begin
                        discard_next = 1'b0;
                    end
                    else
                    begin
                        sum_next     = sum_reg + SUM_W'(shift_reg ^ SAMPLE_MSB);
                        samples_next = (samples_reg == COUNT_MAX) ? COUNT_MAX
                                                                  : samples_reg + COUNT_W'(1);
                    end
                    bit_next   = '0;
                    shift_next = '0;
                    timer_next = '0;
                    if ((samples_next != '0) && (samples_next >= need))
                    begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                    end
                end
            end
            default:
            begin
                clock_next = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign res.sck      = clock_next;
    assign res.busy     = (phase_next != PH_IDLE);
    assign res.done     = done;
    assign calc.sum     = sum_reg;
    assign calc.count   = samples_reg;
    assign calc.is_tare = tare_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bara_div.sv
// Bit-serial restoring divider that forms the average of the summed samples.
`default_nettype none

module bara_div
    import bara_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [SUM_W-1:0]       dividend,
    input  wire logic [COUNT_W-1:0]     divisor,
    output logic                        done,
    output logic [SAMPLE_BITS-1:0]      quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]   quo_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COUNT_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? COUNT_W'(trial - {1'b0, dvs_reg}) : trial[COUNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/bara_mul.sv
// Bit-serial shift-and-add multiplier that keeps the upper half of average times gain.
`default_nettype none

module bara_mul
    import bara_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [SAMPLE_BITS-1:0] multiplicand,
    input  wire logic [GAIN_W-1:0]      multiplier,
    output logic                        done,
    output logic [SAMPLE_BITS-1:0]      product_hi
);

    localparam int CNT_W = $clog2(GAIN_W + 1);

    logic [SAMPLE_BITS-1:0] a_reg;
    logic [GAIN_W-1:0]      b_reg;
    logic [SAMPLE_BITS-1:0] acc_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [SAMPLE_BITS:0]   partial;

    // The low product bits fall off the bottom, so after all gain bits
    // the accumulator holds the product shifted right by the gain width.
    assign partial = {1'b0, acc_reg} + (b_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(GAIN_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= multiplicand;
            b_reg   <= multiplier;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= {1'b0, b_reg[GAIN_W-1:1]};
            acc_reg <= partial[SAMPLE_BITS:1];
        end
    end

    assign done       = done_reg;
    assign product_hi = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bridge_adc_reader_averager_unit.sv
// Top level of the bridge converter reader and averager.
//
//   channel  dir  fields                                       accepted when
//   cmd      in   op, dout_level                               valid && ready
//   rsp      out  sck_level, busy_res, weight_valid, weight    valid && ready
//   wr_*     in   wr_index, wr_data                            wr_en
//
// Each request yields one result. The result of a plain tick sits in the output
// register in the cycle after the tick is accepted. The tick that finishes a
// measurement runs in steps: register the start, load the divider, let the serial
// divider take one sum bit per cycle, hand over to the multiplier, let the serial
// multiplier take one gain bit per cycle, then apply the offset.
// Requests are held off while that runs or while a result is stalled and not taken.
// Reset is asynchronous and needs no sweep.
`default_nettype none

module bridge_adc_reader_averager_unit
    import bara_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    bara_in_if.sink                   cmd,
    bara_out_if.source                rsp,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0]     wr_data
);

    logic [COUNT_W-1:0]         count_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [WEIGHT_W-1:0] offset_reg;

    calc_state_t                cs_reg, cs_next;
    logic                       out_valid_reg;
    logic                       out_sck_reg;
    logic                       out_busy_reg;
    logic                       out_wvalid_reg;
    logic signed [WEIGHT_W-1:0] out_weight_reg;
    logic                       div_go_reg;
    logic                       hold_sck_reg;

    logic                       accept;
    step_res_t                  res;
    calc_op_t                   calc;
    logic                       div_done;
    logic [SAMPLE_BITS-1:0]     average;
    logic                       mul_done;
    logic [SAMPLE_BITS-1:0]     scaled;
    logic signed [SUB_W-1:0]    wide;
    logic signed [WEIGHT_W-1:0] weight_sat;

    localparam logic signed [SUB_W-1:0] W_MAX =
        {{(SUB_W-WEIGHT_W+1){1'b0}}, {(WEIGHT_W-1){1'b1}}};
    localparam logic signed [SUB_W-1:0] W_MIN =
        {{(SUB_W-WEIGHT_W+1){1'b1}}, {(WEIGHT_W-1){1'b0}}};

    assign cmd.ready = (cs_reg == CS_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= COUNT_RESET;
            gain_reg   <= GAIN_RESET;
            offset_reg <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_AVG_COUNT: count_reg  <= wr_data[COUNT_W-1:0];
                CFG_GAIN:      gain_reg   <= wr_data[GAIN_W-1:0];
                CFG_OFFSET:    offset_reg <= $signed(wr_data[WEIGHT_W-1:0]);
                default:       ;
            endcase
        end
    end

    bara_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .op            (cmd.op),
        .dout_level    (cmd.dout_level),
        .average_count (count_reg),
        .res           (res),
        .calc          (calc)
    );

    bara_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (calc.sum),
        .divisor  (calc.count),
        .done     (div_done),
        .quotient (average)
    );

    bara_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_done),
        .multiplicand (average),
        .multiplier   (gain_reg),
        .done         (mul_done),
        .product_hi   (scaled)
    );

    always_comb
    begin
        wide = $signed({{(SUB_W-SAMPLE_BITS){1'b0}}, scaled});
        if (!calc.is_tare)
        begin
            wide = wide - SUB_W'(offset_reg);
        end
        if (wide > W_MAX)
        begin
            weight_sat = W_MAX[WEIGHT_W-1:0];
        end
        else if (wide < W_MIN)
        begin
            weight_sat = W_MIN[WEIGHT_W-1:0];
        end
        else
        begin
            weight_sat = wide[WEIGHT_W-1:0];
        end
    end

    always_comb
    begin
        cs_next = cs_reg;
        case (cs_reg)
            CS_IDLE: if (accept && res.done) cs_next = CS_DIV;
            CS_DIV:  if (div_done) cs_next = CS_MUL;
            CS_MUL:  if (mul_done) cs_next = CS_IDLE;
            default: cs_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg        <= CS_IDLE;
            out_valid_reg <= 1'b0;
            div_go_reg    <= 1'b0;
        end
        else
        begin
            cs_reg     <= cs_next;
            div_go_reg <= accept && res.done;
            if (accept && !res.done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if ((cs_reg == CS_MUL) && mul_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_sck_reg <= res.sck;
        end
        if (accept && !res.done)
        begin
            out_sck_reg    <= res.sck;
            out_busy_reg   <= res.busy;
            out_wvalid_reg <= 1'b0;
            out_weight_reg <= '0;
        end
        else if ((cs_reg == CS_MUL) && mul_done)
        begin
            out_sck_reg    <= hold_sck_reg;
            out_busy_reg   <= 1'b0;
            out_wvalid_reg <= 1'b1;
            out_weight_reg <= weight_sat;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.sck_level    = out_sck_reg;
    assign rsp.busy_res     = out_busy_reg;
    assign rsp.weight_valid = out_wvalid_reg;
    assign rsp.weight       = out_weight_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bara_checker.sv
// Port-level checker of the bridge converter reader and its bind statement.
`default_nettype none

`include "assert_macros.svh"

module bara_checker
    import bara_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bara_in_if.sink    cmd,
    bara_out_if.source rsp
);

    `ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready, rsp.valid, "Result dropped while stalled.")
    `ASSERT_NEXT(a_rsp_stable, rsp.valid && !rsp.ready, $stable(rsp.weight) && $stable(rsp.weight_valid), "Stalled result changed.")
    `ASSERT_IMPL(a_weight_zero, rsp.valid && !rsp.weight_valid, rsp.weight == '0, "Weight is not zero on a plain tick.")
    `ASSERT_IMPL(a_done_idle, rsp.valid && rsp.weight_valid, !rsp.busy_res && !rsp.sck_level, "Finished measurement still busy or clocking.")

endmodule

bind bridge_adc_reader_averager_unit bara_checker u_bara_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
);

`default_nettype wire
